@@ hdl/s16d_pkg.sv @@
// Shared types, constants and layout tables for the Simple-16 word decoder.
// Used by simple16_word_decoder and its bench; depends on nothing else.
package s16d_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned SelW     = 4;
  localparam int unsigned PayloadW = 28;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned OutDataW = 40;  // value + slot + layout, padded to bytes

  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic [SlotW-1:0]    pos;
    logic [SlotW-1:0]    width;
    logic [SlotW-1:0]    slot;
    logic [SelW-1:0]     sel;
    logic                last;
    logic                eol;
  } lane_t;

  // Number of integers held by a word of the given layout
  function automatic logic [SlotW-1:0] field_count(input logic [SelW-1:0] sel);
    logic [SlotW-1:0] c;
    case (sel)
      4'd0:    c = 5'd28;
      4'd1:    c = 5'd21;
      4'd2:    c = 5'd21;
      4'd3:    c = 5'd21;
      4'd4:    c = 5'd14;
      4'd5:    c = 5'd9;
      4'd6:    c = 5'd8;
      4'd7:    c = 5'd7;
      4'd8:    c = 5'd6;
      4'd9:    c = 5'd6;
      4'd10:   c = 5'd5;
      4'd11:   c = 5'd5;
      4'd12:   c = 5'd4;
      4'd13:   c = 5'd3;
      4'd14:   c = 5'd2;
      default: c = 5'd1;
    endcase
    return c;
  endfunction

  // Bit width of the integer at a given slot of a layout
  function automatic logic [SlotW-1:0] field_width(input logic [SelW-1:0]  sel,
                                                   input logic [SlotW-1:0] slot);
    logic [SlotW-1:0] w;
    case (sel)
      4'd0:    w = 5'd1;
      4'd1:    w = (slot < 5'd7) ? 5'd2 : 5'd1;
      4'd2:    w = (slot < 5'd7) ? 5'd1 : ((slot < 5'd14) ? 5'd2 : 5'd1);
      4'd3:    w = (slot < 5'd14) ? 5'd1 : 5'd2;
      4'd4:    w = 5'd2;
      4'd5:    w = (slot < 5'd1) ? 5'd4 : 5'd3;
      4'd6:    w = (slot < 5'd1) ? 5'd3 : ((slot < 5'd5) ? 5'd4 : 5'd3);
      4'd7:    w = 5'd4;
      4'd8:    w = (slot < 5'd4) ? 5'd5 : 5'd4;
      4'd9:    w = (slot < 5'd2) ? 5'd4 : 5'd5;
      4'd10:   w = (slot < 5'd3) ? 5'd6 : 5'd5;
      4'd11:   w = (slot < 5'd2) ? 5'd5 : 5'd6;
      4'd12:   w = 5'd7;
      4'd13:   w = (slot < 5'd1) ? 5'd10 : 5'd9;
      4'd14:   w = 5'd14;
      default: w = 5'd28;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/simple16_word_decoder.sv @@
// Simple-16 word decoder: one 32-bit code word in, its packed integers out.
// The first integer of a word passes the sequencer, shift and mask registers on its way out.
// Throughput: one integer per cycle while m_axis_tready_i holds; a word occupies the slot
// sequencer for field_count(layout) integers (1 to 28), and the next word is taken in the cycle
// its predecessor's last integer leaves the sequencer. Stages: sequencer, shift, mask.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers are not reset.
module simple16_word_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [s16d_pkg::WordW-1:0]      s_axis_tdata_i,   // [31:0] code_word
  input  logic                            s_axis_tlast_i,   // end_of_list
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [27:0] value, [32:28] slot, [36:33] layout, [39:37] zero
  output logic [s16d_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tlast_o,   // word_done
  output logic                            m_axis_tuser_o    // list_done
);

  // ---------------- stage A: slot sequencer ----------------
  logic                              a_vld_q;
  logic [s16d_pkg::PayloadW-1:0]     a_payload_q;
  logic [s16d_pkg::SelW-1:0]         a_sel_q;
  logic                              a_eol_q;
  logic [s16d_pkg::SlotW-1:0]        a_slot_q, a_slot_d;
  logic [s16d_pkg::SlotW-1:0]        a_pos_q, a_pos_d;
  logic [s16d_pkg::SlotW-1:0]        a_width;
  logic [s16d_pkg::SlotW-1:0]        a_count;
  logic                              a_last;
  logic                              a_fire;
  logic                              in_fire;

  // ---------------- stage B: shift ----------------
  logic                              b_vld_q;
  s16d_pkg::lane_t                   b_lane_q, b_lane_d;
  logic                              b_rdy;

  // ---------------- stage C: mask / output register ----------------
  logic                              c_vld_q;
  logic [s16d_pkg::PayloadW-1:0]     c_shift_q, c_shift_d;
  logic [s16d_pkg::SlotW-1:0]        c_width_q;
  logic [s16d_pkg::SlotW-1:0]        c_slot_q;
  logic [s16d_pkg::SelW-1:0]         c_sel_q;
  logic                              c_last_q;
  logic                              c_list_q;
  logic                              c_rdy;
  logic [s16d_pkg::PayloadW-1:0]     c_value;

  assign c_rdy = !c_vld_q || m_axis_tready_i;
  assign b_rdy = !b_vld_q || c_rdy;

  assign a_count = s16d_pkg::field_count(a_sel_q);
  assign a_width = s16d_pkg::field_width(a_sel_q, a_slot_q);
  assign a_last  = (a_slot_q == (a_count - 5'd1));
  assign a_fire  = a_vld_q && b_rdy;

  // take a new word when idle or once the current one hands over its last integer
  assign s_axis_tready_o = !a_vld_q || (a_fire && a_last);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    a_slot_d = a_slot_q;
    a_pos_d  = a_pos_q;
    if (in_fire) begin
      a_slot_d = '0;
      a_pos_d  = '0;
    end else if (a_fire) begin
      a_slot_d = a_slot_q + 5'd1;
      a_pos_d  = a_pos_q + a_width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_fire) begin
      a_vld_q <= 1'b1;
    end else if (a_fire && a_last) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_payload_q <= s_axis_tdata_i[s16d_pkg::WordW-1:s16d_pkg::SelW];
      a_sel_q     <= s_axis_tdata_i[s16d_pkg::SelW-1:0];
      a_eol_q     <= s_axis_tlast_i;
    end
    a_slot_q <= a_slot_d;
    a_pos_q  <= a_pos_d;
  end

  always_comb begin
    b_lane_d.payload = a_payload_q;
    b_lane_d.pos     = a_pos_q;
    b_lane_d.width   = a_width;
    b_lane_d.slot    = a_slot_q;
    b_lane_d.sel     = a_sel_q;
    b_lane_d.last    = a_last;
    b_lane_d.eol     = a_eol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_rdy) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_lane_q <= b_lane_d;
    end
  end

  // align the field to bit 0
  assign c_shift_d = b_lane_q.payload >> b_lane_q.pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (c_rdy) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_vld_q && c_rdy) begin
      c_shift_q <= c_shift_d;
      c_width_q <= b_lane_q.width;
      c_slot_q  <= b_lane_q.slot;
      c_sel_q   <= b_lane_q.sel;
      c_last_q  <= b_lane_q.last;
      c_list_q  <= b_lane_q.last && b_lane_q.eol;
    end
  end

  // drop bits above the field width
  assign c_value = c_shift_q & ~({s16d_pkg::PayloadW{1'b1}} << c_width_q);

  assign m_axis_tvalid_o = c_vld_q;
  assign m_axis_tdata_o  = {3'b000, c_sel_q, c_slot_q, c_value};
  assign m_axis_tlast_o  = c_last_q;
  assign m_axis_tuser_o  = c_list_q;

  // ---------------- assertions ----------------
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (c_slot_q == (s16d_pkg::field_count(c_sel_q) - 5'd1)))
    else $error("word_done not on the final slot of its layout");

  a_list_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("list_done raised on an integer that does not end its word");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> (a_slot_q < a_count))
    else $error("sequencer slot ran past the layout count");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> ((a_pos_q + a_width) <= 6'(s16d_pkg::PayloadW)))
    else $error("field extends beyond the payload");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (a_vld_q && (a_slot_q == '0) && (a_pos_q == '0)))
    else $error("accepted word did not start at slot zero");

endmodule

@@ bench/tb_simple16_word_decoder.sv @@
// Self-checking bench for simple16_word_decoder: streams Simple-16 code words in
// and compares every decoded integer with its own unpacking of the word.
// Depends on s16d_pkg and simple16_word_decoder.
`timescale 1ns / 1ps

module tb_simple16_word_decoder;

  typedef struct packed {
    logic [s16d_pkg::PayloadW-1:0] value;
    logic [s16d_pkg::SlotW-1:0]    slot;
    logic [s16d_pkg::SelW-1:0]     layout;
    logic                          word_done;
    logic                          list_done;
  } decoded_int_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [s16d_pkg::WordW-1:0]    s_axis_tdata = '0;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [s16d_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;

  decoded_int_t pending_ints[$];
  decoded_int_t want_int;
  decoded_int_t got_int;
  int           err_cnt = 0;
  int           sink_hold = 0;
  bit           src_burst = 1'b0;
  bit           sink_burst = 1'b0;

  simple16_word_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Runs of {count, width} per layout, first run in the top bytes
  function automatic logic [47:0] layout_runs(input logic [s16d_pkg::SelW-1:0] sel);
    logic [47:0] r;
    case (sel)
      4'd0:    r = {8'd28, 8'd1,  8'd0,  8'd0, 8'd0, 8'd0};
      4'd1:    r = {8'd7,  8'd2,  8'd14, 8'd1, 8'd0, 8'd0};
      4'd2:    r = {8'd7,  8'd1,  8'd7,  8'd2, 8'd7, 8'd1};
      4'd3:    r = {8'd14, 8'd1,  8'd7,  8'd2, 8'd0, 8'd0};
      4'd4:    r = {8'd14, 8'd2,  8'd0,  8'd0, 8'd0, 8'd0};
      4'd5:    r = {8'd1,  8'd4,  8'd8,  8'd3, 8'd0, 8'd0};
      4'd6:    r = {8'd1,  8'd3,  8'd4,  8'd4, 8'd3, 8'd3};
      4'd7:    r = {8'd7,  8'd4,  8'd0,  8'd0, 8'd0, 8'd0};
      4'd8:    r = {8'd4,  8'd5,  8'd2,  8'd4, 8'd0, 8'd0};
      4'd9:    r = {8'd2,  8'd4,  8'd4,  8'd5, 8'd0, 8'd0};
      4'd10:   r = {8'd3,  8'd6,  8'd2,  8'd5, 8'd0, 8'd0};
      4'd11:   r = {8'd2,  8'd5,  8'd3,  8'd6, 8'd0, 8'd0};
      4'd12:   r = {8'd4,  8'd7,  8'd0,  8'd0, 8'd0, 8'd0};
      4'd13:   r = {8'd1,  8'd10, 8'd2,  8'd9, 8'd0, 8'd0};
      4'd14:   r = {8'd2,  8'd14, 8'd0,  8'd0, 8'd0, 8'd0};
      default: r = {8'd1,  8'd28, 8'd0,  8'd0, 8'd0, 8'd0};
    endcase
    return r;
  endfunction

  // Unpack one code word into the integers it must produce, in order
  function automatic void queue_word_ints(input logic [s16d_pkg::WordW-1:0] word,
                                          input logic eol);
    logic [47:0]                   runs;
    logic [s16d_pkg::PayloadW-1:0] payload;
    logic [31:0]                   mask;
    logic [31:0]                   field;
    decoded_int_t                  d;
    int                            total;
    int                            pos;
    int                            k;
    int                            cnt;
    int                            wid;
    runs    = layout_runs(word[3:0]);
    payload = word[31:4];
    total   = runs[47:40] + runs[31:24] + runs[15:8];
    pos     = 0;
    k       = 0;
    for (int s = 0; s < 3; s++) begin
      cnt  = runs[47 - 16 * s -: 8];
      wid  = runs[39 - 16 * s -: 8];
      mask = (32'd1 << wid) - 32'd1;
      for (int i = 0; i < cnt; i++) begin
        field       = (32'(payload) >> pos) & mask;
        d.value     = field[s16d_pkg::PayloadW-1:0];
        d.slot      = k[s16d_pkg::SlotW-1:0];
        d.layout    = word[3:0];
        d.word_done = (k + 1 == total);
        d.list_done = (k + 1 == total) && eol;
        pending_ints.push_back(d);
        pos += wid;
        k++;
      end
    end
  endfunction

  // Offer one word after a random gap (none in burst mode) and hold it until the block takes it
  task automatic send_word(input logic [s16d_pkg::WordW-1:0] word, input logic eol);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tlast  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queue_word_ints(word, eol);
  endtask

  // Output side: check each accepted item, then drop ready at random, except in burst mode
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_int = {m_axis_tdata[27:0], m_axis_tdata[32:28], m_axis_tdata[36:33],
                 m_axis_tlast, m_axis_tuser};
      if (pending_ints.size() == 0) begin
        $display("%0t: unexpected item: expected none, got %h", $time, got_int);
        err_cnt++;
      end else begin
        want_int = pending_ints.pop_front();
        if (got_int.value !== want_int.value) begin
          $display("%0t: value mismatch: expected %h, got %h", $time,
                   want_int.value, got_int.value);
          err_cnt++;
        end
        if (got_int.slot !== want_int.slot) begin
          $display("%0t: slot mismatch: expected %0d, got %0d", $time,
                   want_int.slot, got_int.slot);
          err_cnt++;
        end
        if (got_int.layout !== want_int.layout) begin
          $display("%0t: layout mismatch: expected %0d, got %0d", $time,
                   want_int.layout, got_int.layout);
          err_cnt++;
        end
        if (got_int.word_done !== want_int.word_done) begin
          $display("%0t: word_done mismatch: expected %b, got %b", $time,
                   want_int.word_done, got_int.word_done);
          err_cnt++;
        end
        if (got_int.list_done !== want_int.list_done) begin
          $display("%0t: list_done mismatch: expected %b, got %b", $time,
                   want_int.list_done, got_int.list_done);
          err_cnt++;
        end
      end
      sink_hold = sink_burst ? 0 : $urandom_range(0, 12);
    end
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic test_every_layout();
    for (int sel = 0; sel < 16; sel++) begin
      send_word({28'hFFFFFFF, 4'(sel)}, sel == 15);
    end
  endtask

  task automatic test_payload_extremes();
    send_word({28'h0000000, 4'd15}, 1'b1);
    send_word({28'h0000000, 4'd0}, 1'b0);
    send_word({28'hAAAAAAA, 4'd0}, 1'b0);
    send_word({28'h5555555, 4'd0}, 1'b1);
    send_word({28'hAAAAAAA, 4'd14}, 1'b0);
    // padding integers after the true end of a list still come out as zeros
    send_word({28'h0000001, 4'd13}, 1'b1);
  endtask

  task automatic test_random_words(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
      end
      send_word($urandom(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Lists of one to eight words, end flag on the last word only
  task automatic test_lists(input int n);
    int left;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left       = $urandom_range(1, 8);
        src_burst  = ($urandom_range(0, 4) == 0);
        sink_burst = ($urandom_range(0, 4) == 0);
      end
      left--;
      send_word($urandom(), left == 0);
    end
  endtask

  task automatic test_back_to_back(input int n);
    src_burst  = 1'b1;
    sink_burst = 1'b1;
    for (int i = 0; i < n; i++) begin
      // favour short layouts so that word boundaries come close together
      send_word({28'($urandom()), 4'($urandom_range(10, 15))}, 1'($urandom_range(0, 1)));
    end
    src_burst  = 1'b0;
    sink_burst = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_every_layout();
    test_payload_extremes();
    test_random_words(260);
    test_lists(120);
    test_back_to_back(60);
    s_axis_tvalid <= 1'b0;
    sink_burst = 1'b0;
    while (pending_ints.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/s16d_pkg.sv
hdl/simple16_word_decoder.sv
bench/tb_simple16_word_decoder.sv
